// ===== hw/rtl/mrq_pkg.sv =====
package mrq_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DefSlots    = 8;
  localparam int unsigned DefMaxBytes = 32;

  // Width of the length field on the result port.
  localparam int unsigned LenW = 6;

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_WRITE     = 2'd0,
    FUNC_READ_REL  = 2'd1,
    FUNC_READ_KEEP = 2'd2,
    FUNC_RELEASE   = 2'd3
  } mrq_func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } mrq_status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LEN    = 2'd1,
    S_STREAM = 2'd2
  } mrq_state_e;

  typedef struct packed {
    mrq_func_e   func;
    logic [7:0]  in_byte;
    logic        has_byte;
    logic        final_byte;
  } mrq_req_t;

  typedef struct packed {
    mrq_status_e     status;
    logic [7:0]      out_byte;
    logic            out_has_byte;
    logic [LenW-1:0] msg_length;
    logic            end_of_run;
  } mrq_rsp_t;

endpackage

// ===== hw/rtl/mrq_ram.sv =====
module mrq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/message_ring_queue_top.sv =====
// Variable-length message queue: a ring of Slots slots, each holding one message of up to
// MaxBytes bytes. A write request carries at most one byte; the request
// marked final answers with one result (ok, too_long or full). A release request gives
// no result. A read of an empty head gives one empty result. A read of a pending head
// first reads the stored length from its own memory, then fetches the first byte, then
// streams one result per byte, one per cycle while the output is not stalled (a zero-length
// message gives one result with no byte); the single read port of the byte memory sets that
// pace. No request is taken while a read streams. Pending flags clear at reset, so the
// block is ready at once.
module message_ring_queue_top import mrq_pkg::*; #(
  parameter int unsigned Slots    = DefSlots,
  parameter int unsigned MaxBytes = DefMaxBytes
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mrq_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mrq_rsp_t out_rsp_o
);

  localparam int unsigned IdxW  = $clog2(Slots);
  localparam int unsigned CntW  = $clog2(MaxBytes + 1);
  localparam int unsigned Words = Slots * MaxBytes;
  localparam int unsigned AddrW = $clog2(Words);

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx);
    ring_next = (idx == IdxW'(Slots - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [AddrW-1:0] slot_addr(input logic [IdxW-1:0] idx,
                                                  input logic [CntW-1:0] off);
    slot_addr = AddrW'(idx) * AddrW'(MaxBytes) + AddrW'(off);
  endfunction

  mrq_state_e        state_q, state_d;
  mrq_func_e         func_q, func_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [IdxW-1:0]   tail_q, tail_d;
  logic [Slots-1:0]  pend_q, pend_d;
  logic [CntW-1:0]   wcnt_q, wcnt_d;
  logic              wovf_q, wovf_d;
  logic              wdrop_q, wdrop_d;
  logic [CntW-1:0]   rd_len_q, rd_len_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              out_valid_q, out_valid_d;
  mrq_rsp_t          out_q, out_d;

  logic              byte_we, byte_re;
  logic [AddrW-1:0]  byte_waddr, byte_raddr;
  logic [7:0]        byte_rdata;
  logic              len_we, len_re;
  logic [CntW-1:0]   len_wdata, len_rdata;

  logic              out_free;
  logic              accept;

  // The result register is free when empty or being taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Message bytes, one row of MaxBytes per slot.
  mrq_ram #(
    .Width(8),
    .Depth(Words)
  ) u_byte_ram (
    .clk_i  (clk_i),
    .we_i   (byte_we),
    .waddr_i(byte_waddr),
    .wdata_i(in_req_i.in_byte),
    .re_i   (byte_re),
    .raddr_i(byte_raddr),
    .rdata_o(byte_rdata)
  );

  // Stored message length per slot.
  mrq_ram #(
    .Width(CntW),
    .Depth(Slots)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (len_we),
    .waddr_i(tail_q),
    .wdata_i(len_wdata),
    .re_i   (len_re),
    .raddr_i(head_q),
    .rdata_o(len_rdata)
  );

  // Sequencer: write handling, release, and the read stream.
  always_comb begin
    logic [CntW-1:0] cnt_n;
    logic            ovf_n;
    logic            drop_n;
    logic            emit;
    logic            last;
    mrq_rsp_t        rsp;

    state_d    = state_q;
    func_d     = func_q;
    head_d     = head_q;
    tail_d     = tail_q;
    pend_d     = pend_q;
    wcnt_d     = wcnt_q;
    wovf_d     = wovf_q;
    wdrop_d    = wdrop_q;
    rd_len_d   = rd_len_q;
    rd_idx_d   = rd_idx_q;
    byte_we    = 1'b0;
    byte_waddr = slot_addr(tail_q, wcnt_q);
    byte_re    = 1'b0;
    byte_raddr = slot_addr(head_q, '0);
    len_we     = 1'b0;
    len_wdata  = wcnt_q;
    len_re     = 1'b0;
    cnt_n      = wcnt_q;
    ovf_n      = wovf_q;
    drop_n     = wdrop_q;
    emit       = 1'b0;
    last       = 1'b0;
    rsp        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_i.func)
            FUNC_WRITE: begin
              // Store the byte unless the message overflows or the tail is taken.
              if (in_req_i.has_byte) begin
                if (wcnt_q >= CntW'(MaxBytes)) begin
                  ovf_n = 1'b1;
                end else if (pend_q[tail_q]) begin
                  drop_n = 1'b1;
                  cnt_n  = wcnt_q + 1'b1;
                end else begin
                  byte_we = 1'b1;
                  cnt_n   = wcnt_q + 1'b1;
                end
              end
              wcnt_d  = cnt_n;
              wovf_d  = ovf_n;
              wdrop_d = drop_n;
              // The final request settles the message.
              if (in_req_i.final_byte) begin
                emit           = 1'b1;
                rsp.end_of_run = 1'b1;
                if (ovf_n) begin
                  rsp.status = STAT_TOO_LONG;
                end else if (pend_q[tail_q] || drop_n) begin
                  rsp.status = STAT_FULL;
                end else begin
                  rsp.status     = STAT_OK;
                  rsp.msg_length = LenW'(cnt_n);
                  len_we         = 1'b1;
                  len_wdata      = cnt_n;
                  pend_d[tail_q] = 1'b1;
                  tail_d         = ring_next(tail_q);
                end
                wcnt_d  = '0;
                wovf_d  = 1'b0;
                wdrop_d = 1'b0;
              end
            end
            FUNC_RELEASE: begin
              pend_d[head_q] = 1'b0;
              head_d         = ring_next(head_q);
            end
            FUNC_READ_REL, FUNC_READ_KEEP: begin
              if (!pend_q[head_q]) begin
                emit           = 1'b1;
                rsp.status     = STAT_EMPTY;
                rsp.end_of_run = 1'b1;
              end else begin
                len_re  = 1'b1;
                func_d  = in_req_i.func;
                state_d = S_LEN;
              end
            end
            default: ;
          endcase
        end
      end

      S_LEN: begin
        // Length is back; either answer an empty message or fetch the first byte.
        if (len_rdata == '0) begin
          if (out_free) begin
            emit           = 1'b1;
            rsp.status     = STAT_OK;
            rsp.end_of_run = 1'b1;
            last           = 1'b1;
          end
        end else begin
          byte_re    = 1'b1;
          byte_raddr = slot_addr(head_q, '0);
          rd_len_d   = len_rdata;
          rd_idx_d   = '0;
          state_d    = S_STREAM;
        end
      end

      S_STREAM: begin
        // One byte per cycle while the result register drains.
        if (out_free) begin
          emit             = 1'b1;
          rsp.status       = STAT_OK;
          rsp.out_byte     = byte_rdata;
          rsp.out_has_byte = 1'b1;
          rsp.msg_length   = LenW'(rd_len_q);
          if (CntW'(rd_idx_q + 1'b1) == rd_len_q) begin
            rsp.end_of_run = 1'b1;
            last           = 1'b1;
          end else begin
            byte_re    = 1'b1;
            byte_raddr = slot_addr(head_q, CntW'(rd_idx_q + 1'b1));
            rd_idx_d   = CntW'(rd_idx_q + 1'b1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // End of a read: release the head slot if asked, then go idle.
    if (last) begin
      state_d = S_IDLE;
      if (func_q == FUNC_READ_REL) begin
        pend_d[head_q] = 1'b0;
        head_d         = ring_next(head_q);
      end
    end

    // Result register.
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = emit;
      out_d       = rsp;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= FUNC_READ_KEEP;
      head_q      <= '0;
      tail_q      <= '0;
      pend_q      <= '0;
      wcnt_q      <= '0;
      wovf_q      <= 1'b0;
      wdrop_q     <= 1'b0;
      rd_len_q    <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      pend_q      <= pend_d;
      wcnt_q      <= wcnt_d;
      wovf_q      <= wovf_d;
      wdrop_q     <= wdrop_d;
      rd_len_q    <= rd_len_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // A request is never taken while a stalled result blocks the register.
  a_accept_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(out_valid_o && out_stall_i))
    else $error("request accepted while result register is blocked");

  // The open-message count never passes the slot size.
  a_wcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= CntW'(MaxBytes))
    else $error("write count beyond slot size");

  // While streaming, the byte index stays inside the message.
  a_stream_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STREAM) |-> (rd_idx_q < rd_len_q && rd_len_q != '0))
    else $error("stream index outside message");

  // A result carrying a byte reports a nonzero length.
  a_byte_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.out_has_byte) |-> (out_rsp_o.msg_length != '0))
    else $error("byte result with zero length");

  // A read in progress keeps the head slot pending.
  a_read_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEN || state_q == S_STREAM) |-> pend_q[head_q])
    else $error("read of a slot that is not pending");

endmodule
